FILE: hdl/assert_macros.svh
// Assertion helpers shared by the rename unit modules.
// Each module that uses them has a clock i_clk and an active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define RRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rename unit assertion failed");

// Next-cycle implication, ignored while reset is held.
`define RRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rename unit assertion failed");

`endif

FILE: hdl/rru_pkg.sv
`default_nettype none

package rru_pkg;

    localparam int ARCH_REGS = 32;
    localparam int PHYS_REGS = 64;
    localparam int ARCH_W    = $clog2(ARCH_REGS);
    localparam int PHYS_W    = $clog2(PHYS_REGS);
    localparam int CNT_W     = $clog2(PHYS_REGS + 1);
    localparam int FREE_INIT = PHYS_REGS - ARCH_REGS;
    localparam int DATA_W    = 64;
    localparam int IMM_W     = 32;

    typedef enum logic [1:0] {
        FUNC_RENAME    = 2'd0,
        FUNC_WRITEBACK = 2'd1,
        FUNC_RETIRE    = 2'd2,
        FUNC_ROLLBACK  = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]              func;
        logic [ARCH_W-1:0]       arch_dest;
        logic [ARCH_W-1:0]       arch_src_a;
        logic [ARCH_W-1:0]       arch_src_b;
        logic                    b_is_immediate;
        logic signed [IMM_W-1:0] immediate;
        logic [PHYS_W-1:0]       phys_reg;
        logic [DATA_W-1:0]       write_value;
        logic                    has_exception;
    } t_item;

    typedef struct packed {
        logic              accepted;
        logic [PHYS_W-1:0] new_phys_dest;
        logic [PHYS_W-1:0] old_phys_dest;
        logic              a_ready;
        logic [PHYS_W-1:0] a_tag;
        logic [DATA_W-1:0] a_value;
        logic              b_ready;
        logic [PHYS_W-1:0] b_tag;
        logic [DATA_W-1:0] b_value;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [ARCH_W-1:0] addr;
        logic [PHYS_W-1:0] data;
    } t_map_wr;

    typedef struct packed {
        logic              en;
        logic [PHYS_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_val_wr;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic [PHYS_W-1:0] push_data;
    } t_fl_ctl;

endpackage

`default_nettype wire

FILE: hdl/rru_map_table.sv
`default_nettype none

module rru_map_table (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rru_pkg::t_map_wr             i_wr,
    input  wire logic [rru_pkg::ARCH_W-1:0]   i_rd_a,
    input  wire logic [rru_pkg::ARCH_W-1:0]   i_rd_b,
    input  wire logic [rru_pkg::ARCH_W-1:0]   i_rd_d,
    output logic      [rru_pkg::PHYS_W-1:0]   o_q_a,
    output logic      [rru_pkg::PHYS_W-1:0]   o_q_b,
    output logic      [rru_pkg::PHYS_W-1:0]   o_q_d
);

    localparam int AW = rru_pkg::ARCH_W;
    localparam int PW = rru_pkg::PHYS_W;

    // Two copies: one serves both sources, the other the destination.
    logic [PW-1:0] r_mem_src [rru_pkg::ARCH_REGS];
    logic [PW-1:0] r_mem_dst [rru_pkg::ARCH_REGS];
    logic [rru_pkg::ARCH_REGS-1:0] r_vld;

    logic [PW-1:0] r_q_a;
    logic [PW-1:0] r_q_b;
    logic [PW-1:0] r_q_d;
    logic [AW-1:0] r_addr_a;
    logic [AW-1:0] r_addr_b;
    logic [AW-1:0] r_addr_d;

    logic          r_byp_en;
    logic [AW-1:0] r_byp_addr;
    logic [PW-1:0] r_byp_data;

    // An entry never written reads as its own index.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_src[i_wr.addr] <= i_wr.data;
            r_mem_dst[i_wr.addr] <= i_wr.data;
        end
        r_q_a      <= r_vld[i_rd_a] ? r_mem_src[i_rd_a] : PW'(i_rd_a);
        r_q_b      <= r_vld[i_rd_b] ? r_mem_src[i_rd_b] : PW'(i_rd_b);
        r_q_d      <= r_vld[i_rd_d] ? r_mem_dst[i_rd_d] : PW'(i_rd_d);
        r_addr_a   <= i_rd_a;
        r_addr_b   <= i_rd_b;
        r_addr_d   <= i_rd_d;
        r_byp_addr <= i_wr.addr;
        r_byp_data <= i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_byp_en <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_byp_en <= i_wr.en;
        end
    end

    // A write on the same edge as the read misses the array and is bypassed.
    assign o_q_a = (r_byp_en && r_byp_addr == r_addr_a) ? r_byp_data : r_q_a;
    assign o_q_b = (r_byp_en && r_byp_addr == r_addr_b) ? r_byp_data : r_q_b;
    assign o_q_d = (r_byp_en && r_byp_addr == r_addr_d) ? r_byp_data : r_q_d;

endmodule

`default_nettype wire

FILE: hdl/rru_value_file.sv
`default_nettype none

module rru_value_file (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rru_pkg::t_val_wr             i_wr,
    input  wire logic [rru_pkg::PHYS_W-1:0]   i_rd_a,
    input  wire logic [rru_pkg::PHYS_W-1:0]   i_rd_b,
    output logic      [rru_pkg::DATA_W-1:0]   o_q_a,
    output logic      [rru_pkg::DATA_W-1:0]   o_q_b
);

    localparam int DW = rru_pkg::DATA_W;

    logic [DW-1:0] r_mem [rru_pkg::PHYS_REGS];
    logic [rru_pkg::PHYS_REGS-1:0] r_vld;
    logic [DW-1:0] r_q_a;
    logic [DW-1:0] r_q_b;

    // Reads return the contents from before a write on the same edge, which
    // is the order the rename stage needs.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q_a <= r_vld[i_rd_a] ? r_mem[i_rd_a] : '0;
        r_q_b <= r_vld[i_rd_b] ? r_mem[i_rd_b] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_q_a = r_q_a;
    assign o_q_b = r_q_b;

endmodule

`default_nettype wire

FILE: hdl/rru_free_list.sv
`default_nettype none
`include "assert_macros.svh"

module rru_free_list (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rru_pkg::t_fl_ctl             i_ctl,
    output logic      [rru_pkg::PHYS_W-1:0]   o_head_data,
    output logic                              o_empty
);

    localparam int PW = rru_pkg::PHYS_W;
    localparam int CW = rru_pkg::CNT_W;

    logic [PW-1:0] r_mem [rru_pkg::PHYS_REGS];
    logic [rru_pkg::PHYS_REGS-1:0] r_vld;

    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_head;
    logic          w_full;
    logic          w_push;

    logic [PW-1:0] r_q;
    logic [PW-1:0] r_rd_addr;
    logic          r_byp_en;
    logic [PW-1:0] r_byp_addr;
    logic [PW-1:0] r_byp_data;

    function automatic logic [PW-1:0] reset_entry(input logic [PW-1:0] idx);
        logic [PW-1:0] val;
        if (int'(idx) < rru_pkg::FREE_INIT) begin
            val = PW'(rru_pkg::ARCH_REGS + int'(idx));
        end else begin
            val = '0;
        end
        return val;
    endfunction

    assign o_empty = (r_count == '0);
    assign w_full  = (r_count == CW'(rru_pkg::PHYS_REGS));
    // A push into a full list is dropped.
    assign w_push  = i_ctl.push && !w_full;
    assign n_head  = i_ctl.pop ? PW'(r_head + 1'b1) : r_head;

    // The entry at the next head is registered ahead of its pop.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_ctl.push_data;
        end
        r_q        <= r_vld[n_head] ? r_mem[n_head] : reset_entry(n_head);
        r_rd_addr  <= n_head;
        r_byp_addr <= r_tail;
        r_byp_data <= i_ctl.push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_head   <= '0;
            r_tail   <= PW'(rru_pkg::FREE_INIT);
            r_count  <= CW'(rru_pkg::FREE_INIT);
            r_byp_en <= 1'b0;
        end else begin
            if (w_push) begin
                r_vld[r_tail] <= 1'b1;
                r_tail        <= PW'(r_tail + 1'b1);
            end
            r_head   <= n_head;
            r_byp_en <= w_push;
            if (w_push && !i_ctl.pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (i_ctl.pop && !w_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    assign o_head_data = (r_byp_en && r_byp_addr == r_rd_addr) ? r_byp_data : r_q;

    `RRU_ASSERT_IMP(a_fl_pop_nonempty, i_ctl.pop, r_count != '0)
    `RRU_ASSERT_IMP(a_fl_count_max, 1'b1, r_count <= CW'(rru_pkg::PHYS_REGS))
    `RRU_ASSERT_IMP(a_fl_ring, 1'b1, r_tail == PW'(r_head + r_count))

endmodule

`default_nettype wire

FILE: hdl/register_rename_unit_core.sv
// Channel  | Direction | Handshake                       | Payload
// ---------+-----------+---------------------------------+------------------
// item     | in        | start high while busy is low    | i_item (t_item)
// result   | out       | o_strobe high for one cycle     | o_result (t_result)
//
// One item is accepted every cycle; busy never rises.
// Each result passes in order through the registered map-table and free-list
// reads, the value-file read and the result register.
// State updates are decided in the cycle after acceptance and land at its end, so
// consecutive items see each other in order through a one-entry write bypass in
// front of the map and free list.
// Reset is synchronous and clears all valid bits at once; no clearing pass.
// The receiver cannot stall results.
`default_nettype none
`include "assert_macros.svh"

module register_rename_unit_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire rru_pkg::t_item   i_item,
    output logic                  busy,
    output logic                  o_strobe,
    output rru_pkg::t_result      o_result
);

    localparam int PW = rru_pkg::PHYS_W;
    localparam int DW = rru_pkg::DATA_W;
    localparam int IW = rru_pkg::IMM_W;

    logic             w_acc;
    logic             r_s1_vld;
    rru_pkg::t_item   r_s1_item;

    logic [PW-1:0]    w_pa;
    logic [PW-1:0]    w_pb;
    logic [PW-1:0]    w_pd;
    logic [PW-1:0]    w_np;
    logic             w_fl_empty;

    rru_pkg::t_map_wr w_map_wr;
    rru_pkg::t_val_wr w_val_wr;
    rru_pkg::t_fl_ctl w_fl_ctl;

    logic             w_busy_set;
    logic             w_busy_clr;
    logic [PW-1:0]    w_busy_addr;
    logic             w_ren_ok;
    logic             w_stall;
    logic [rru_pkg::PHYS_REGS-1:0] r_busy;

    logic             r_s2_vld;
    logic             r_s2_ren;
    logic             r_s2_acc;
    logic [PW-1:0]    r_s2_np;
    logic [PW-1:0]    r_s2_op;
    logic             r_s2_a_busy;
    logic [PW-1:0]    r_s2_a_tag;
    logic             r_s2_b_busy;
    logic [PW-1:0]    r_s2_b_tag;
    logic             r_s2_b_imm;
    logic [DW-1:0]    r_s2_imm;

    logic [DW-1:0]    w_val_a;
    logic [DW-1:0]    w_val_b;

    rru_pkg::t_result n_res;
    rru_pkg::t_result r_res;
    logic             r_strobe;

    // Every item flows through without waiting, so there is nothing to hold off.
    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        r_s1_item <= i_item;
    end

    rru_map_table u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_map_wr),
        .i_rd_a  (i_item.arch_src_a),
        .i_rd_b  (i_item.arch_src_b),
        .i_rd_d  (i_item.arch_dest),
        .o_q_a   (w_pa),
        .o_q_b   (w_pb),
        .o_q_d   (w_pd)
    );

    rru_free_list u_free (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_fl_ctl),
        .o_head_data (w_np),
        .o_empty     (w_fl_empty)
    );

    rru_value_file u_values (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_val_wr),
        .i_rd_a  (w_pa),
        .i_rd_b  (w_pb),
        .o_q_a   (w_val_a),
        .o_q_b   (w_val_b)
    );

    // Commit stage: decide the item's effect on the map, free list, busy bits
    // and value file.
    always_comb begin
        w_map_wr    = '0;
        w_val_wr    = '0;
        w_fl_ctl    = '0;
        w_busy_set  = 1'b0;
        w_busy_clr  = 1'b0;
        w_busy_addr = r_s1_item.phys_reg;
        w_ren_ok    = 1'b0;
        w_stall     = 1'b0;
        w_map_wr.addr      = r_s1_item.arch_dest;
        w_fl_ctl.push_data = r_s1_item.phys_reg;
        if (r_s1_vld) begin
            case (r_s1_item.func)
                rru_pkg::FUNC_RENAME: begin
                    if (w_fl_empty) begin
                        w_stall = 1'b1;
                    end else begin
                        w_ren_ok        = 1'b1;
                        w_fl_ctl.pop    = 1'b1;
                        w_map_wr.en     = 1'b1;
                        w_map_wr.data   = w_np;
                        w_val_wr.en     = 1'b1;
                        w_val_wr.addr   = w_np;
                        w_val_wr.data   = '0;
                        w_busy_set      = 1'b1;
                        w_busy_addr     = w_np;
                    end
                end
                rru_pkg::FUNC_WRITEBACK: begin
                    w_val_wr.en   = 1'b1;
                    w_val_wr.addr = r_s1_item.phys_reg;
                    w_val_wr.data = r_s1_item.write_value;
                    w_busy_clr    = !r_s1_item.has_exception;
                end
                rru_pkg::FUNC_RETIRE: begin
                    w_busy_clr    = 1'b1;
                    w_fl_ctl.push = 1'b1;
                end
                rru_pkg::FUNC_ROLLBACK: begin
                    w_map_wr.en        = 1'b1;
                    w_map_wr.data      = r_s1_item.phys_reg;
                    w_busy_clr         = 1'b1;
                    w_busy_addr        = w_pd;
                    w_fl_ctl.push      = 1'b1;
                    w_fl_ctl.push_data = w_pd;
                end
                default: begin
                    w_stall = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ren    <= w_ren_ok;
        r_s2_acc    <= !w_stall;
        r_s2_np     <= w_np;
        r_s2_op     <= w_pd;
        r_s2_a_busy <= r_busy[w_pa];
        r_s2_a_tag  <= w_pa;
        r_s2_b_busy <= r_busy[w_pb];
        r_s2_b_tag  <= w_pb;
        r_s2_b_imm  <= r_s1_item.b_is_immediate;
        r_s2_imm    <= {{(DW-IW){r_s1_item.immediate[IW-1]}}, r_s1_item.immediate};
        r_res       <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_s1_vld <= w_acc;
            r_s2_vld <= r_s1_vld;
            r_strobe <= r_s2_vld;
            if (w_busy_set) begin
                r_busy[w_busy_addr] <= 1'b1;
            end else if (w_busy_clr) begin
                r_busy[w_busy_addr] <= 1'b0;
            end
        end
    end

    // Result assembly: fields that carry no meaning for an item stay zero.
    always_comb begin
        n_res          = '0;
        n_res.accepted = r_s2_acc;
        if (r_s2_ren) begin
            n_res.new_phys_dest = r_s2_np;
            n_res.old_phys_dest = r_s2_op;
            n_res.a_ready       = !r_s2_a_busy;
            n_res.a_tag         = r_s2_a_busy ? r_s2_a_tag : '0;
            n_res.a_value       = r_s2_a_busy ? '0 : w_val_a;
            if (r_s2_b_imm) begin
                n_res.b_ready = 1'b1;
                n_res.b_value = r_s2_imm;
            end else begin
                n_res.b_ready = !r_s2_b_busy;
                n_res.b_tag   = r_s2_b_busy ? r_s2_b_tag : '0;
                n_res.b_value = r_s2_b_busy ? '0 : w_val_b;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `RRU_ASSERT_IMP(a_latency, start && !busy, ##3 o_strobe)
    `RRU_ASSERT_IMP(a_stall_empty, o_strobe && !o_result.accepted, $past(w_fl_empty, 2))
    `RRU_ASSERT_IMP(a_no_double_busy_op, w_busy_set, !w_busy_clr)

endmodule

`default_nettype wire

FILE: verif/rename_check.sv
`default_nettype none

module rename_check
    import rru_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_busy,
    input  wire t_item   i_item,
    input  wire logic    i_strobe,
    input  wire t_result i_result,
    output int           o_fail_count,
    output int           o_pending
);

    logic [PHYS_W-1:0] arch_map [ARCH_REGS];
    logic [PHYS_W-1:0] free_ring [PHYS_REGS];
    int                ring_head;
    int                ring_tail;
    int                ring_count;
    logic              reg_busy [PHYS_REGS];
    logic [DATA_W-1:0] reg_value [PHYS_REGS];
    t_result           awaited_results [$];
    int                mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_rename_state();
        for (int i = 0; i < ARCH_REGS; i++) begin
            arch_map[i] = PHYS_W'(i);
        end
        for (int i = 0; i < PHYS_REGS; i++) begin
            reg_busy[i]  = 1'b0;
            reg_value[i] = '0;
            free_ring[i] = (i < FREE_INIT) ? PHYS_W'(ARCH_REGS + i) : '0;
        end
        ring_head  = 0;
        ring_tail  = FREE_INIT % PHYS_REGS;
        ring_count = FREE_INIT;
    endfunction

    // A push onto a full free list is silently dropped.
    function automatic void release_reg(input logic [PHYS_W-1:0] preg);
        if (ring_count < PHYS_REGS) begin
            free_ring[ring_tail] = preg;
            ring_tail            = (ring_tail + 1) % PHYS_REGS;
            ring_count++;
        end
    endfunction

    function automatic void read_operand(input logic [ARCH_W-1:0] areg, output logic rdy,
                                         output logic [PHYS_W-1:0] tag,
                                         output logic [DATA_W-1:0] val);
        logic [PHYS_W-1:0] preg;
        preg = arch_map[areg];
        if (reg_busy[preg]) begin
            rdy = 1'b0;
            tag = preg;
            val = '0;
        end else begin
            rdy = 1'b1;
            tag = '0;
            val = reg_value[preg];
        end
    endfunction

    function automatic t_result rename_predict(input t_item it);
        t_result           res;
        logic [PHYS_W-1:0] fresh;
        logic [PHYS_W-1:0] cur;
        res          = '0;
        res.accepted = 1'b1;
        case (t_func'(it.func))
            FUNC_RENAME: begin
                if (ring_count == 0) begin
                    res.accepted = 1'b0;
                end else begin
                    fresh     = free_ring[ring_head];
                    ring_head = (ring_head + 1) % PHYS_REGS;
                    ring_count--;
                    res.new_phys_dest = fresh;
                    res.old_phys_dest = arch_map[it.arch_dest];
                    // Sources see the map as it stood before this rename.
                    read_operand(it.arch_src_a, res.a_ready, res.a_tag, res.a_value);
                    if (it.b_is_immediate) begin
                        res.b_ready = 1'b1;
                        res.b_value = {{(DATA_W - IMM_W){it.immediate[IMM_W-1]}},
                                       it.immediate};
                    end else begin
                        read_operand(it.arch_src_b, res.b_ready, res.b_tag, res.b_value);
                    end
                    arch_map[it.arch_dest] = fresh;
                    reg_value[fresh]       = '0;
                    reg_busy[fresh]        = 1'b1;
                end
            end
            FUNC_WRITEBACK: begin
                reg_value[it.phys_reg] = it.write_value;
                if (!it.has_exception) begin
                    reg_busy[it.phys_reg] = 1'b0;
                end
            end
            FUNC_RETIRE: begin
                reg_busy[it.phys_reg] = 1'b0;
                release_reg(it.phys_reg);
            end
            default: begin
                cur                    = arch_map[it.arch_dest];
                arch_map[it.arch_dest] = it.phys_reg;
                reg_busy[cur]          = 1'b0;
                release_reg(cur);
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_rename_state();
            awaited_results.delete();
        end else begin
            // An unknown strobe is treated as a result so that it cannot slip through.
            if (i_strobe !== 1'b0) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result arrived with nothing awaited: %h", $time,
                                 i_result);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.accepted !== want.accepted
                        || i_result.new_phys_dest !== want.new_phys_dest
                        || i_result.old_phys_dest !== want.old_phys_dest
                        || i_result.a_ready !== want.a_ready
                        || i_result.a_tag !== want.a_tag
                        || i_result.a_value !== want.a_value
                        || i_result.b_ready !== want.b_ready
                        || i_result.b_tag !== want.b_tag
                        || i_result.b_value !== want.b_value) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch acc/new/old/ardy/atag/aval/brdy/btag/bval",
                                     $time);
                            $display("  expected %b %0d %0d %b %0d %h %b %0d %h",
                                     want.accepted, want.new_phys_dest, want.old_phys_dest,
                                     want.a_ready, want.a_tag, want.a_value,
                                     want.b_ready, want.b_tag, want.b_value);
                            $display("  actual   %b %0d %0d %b %0d %h %b %0d %h",
                                     i_result.accepted, i_result.new_phys_dest,
                                     i_result.old_phys_dest, i_result.a_ready,
                                     i_result.a_tag, i_result.a_value, i_result.b_ready,
                                     i_result.b_tag, i_result.b_value);
                        end
                    end
                end
            end
            if (i_start && i_busy === 1'b0) begin
                awaited_results.push_back(rename_predict(i_item));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
    import rru_pkg::*;

    localparam int PHASES       = 11;
    localparam int PHASE_ITEMS  = 50;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 6;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;
    int      failures;
    int      pending;

    logic [PHYS_W-1:0] recent_new [$];
    logic [PHYS_W-1:0] recent_old [$];
    logic              burst       = 1'b0;
    logic              finished    = 1'b0;
    int                idle_cycles = 0;

    register_rename_unit_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    rename_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (failures),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Registers recently handed out and displaced, so that writebacks, retires and
    // rollbacks mostly name registers that are really in flight.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1 && o_result.accepted === 1'b1
            && (o_result.new_phys_dest != 0 || o_result.old_phys_dest != 0)) begin
            recent_new.push_back(o_result.new_phys_dest);
            recent_old.push_back(o_result.old_phys_dest);
            if (recent_new.size() > 16) begin
                void'(recent_new.pop_front());
                void'(recent_old.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !finished) begin
            if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_item(input t_item it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    function automatic logic [PHYS_W-1:0] pick_reg(input logic from_new);
        if (from_new && recent_new.size() > 0) begin
            return recent_new[$urandom_range(0, recent_new.size() - 1)];
        end else if (!from_new && recent_old.size() > 0) begin
            return recent_old[$urandom_range(0, recent_old.size() - 1)];
        end
        return PHYS_W'($urandom_range(0, PHYS_REGS - 1));
    endfunction

    function automatic t_item random_item(input int rename_pct, input int retire_pct);
        t_item it;
        int    roll;
        it.arch_dest      = ARCH_W'($urandom_range(0, ARCH_REGS - 1));
        it.arch_src_a     = ARCH_W'($urandom_range(0, ARCH_REGS - 1));
        it.arch_src_b     = ARCH_W'($urandom_range(0, ARCH_REGS - 1));
        it.b_is_immediate = 1'($urandom_range(0, 1));
        it.phys_reg       = PHYS_W'($urandom_range(0, PHYS_REGS - 1));
        it.has_exception  = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0:       it.immediate = 32'sh8000_0000;
            1:       it.immediate = 32'sh7fff_ffff;
            2:       it.immediate = -32'sd1;
            default: it.immediate = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       it.write_value = '1;
            1:       it.write_value = '0;
            default: it.write_value = {$urandom, $urandom};
        endcase
        roll = $urandom_range(0, 99);
        if (roll < rename_pct) begin
            it.func = FUNC_RENAME;
        end else if (roll < rename_pct + retire_pct) begin
            it.func = FUNC_RETIRE;
            if ($urandom_range(0, 4) != 0) it.phys_reg = pick_reg(1'b0);
        end else if (roll < rename_pct + retire_pct + 8) begin
            it.func = FUNC_ROLLBACK;
            if ($urandom_range(0, 3) != 0) it.phys_reg = pick_reg(1'b0);
        end else begin
            it.func = FUNC_WRITEBACK;
            if ($urandom_range(0, 6) != 0) it.phys_reg = pick_reg(1'b1);
        end
        return it;
    endfunction

    initial begin
        t_item it;
        int    rename_pct;
        int    retire_pct;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Renames against the reset map, with both immediate extremes.
        it = '0; it.func = FUNC_RENAME; it.arch_dest = 5'd1; it.arch_src_b = 5'd31;
        send_item(it);
        it = '0; it.func = FUNC_RENAME; it.arch_dest = 5'd31; it.arch_src_a = 5'd1;
        it.b_is_immediate = 1'b1; it.immediate = 32'sh8000_0000;
        send_item(it);
        it = '0; it.func = FUNC_RENAME; it.arch_src_a = 5'd31;
        it.b_is_immediate = 1'b1; it.immediate = 32'sh7fff_ffff;
        send_item(it);
        // A clean writeback, then one carrying an exception, which leaves busy set.
        it = '0; it.func = FUNC_WRITEBACK; it.phys_reg = 6'd32; it.write_value = '1;
        send_item(it);
        it = '0; it.func = FUNC_WRITEBACK; it.phys_reg = 6'd33;
        it.write_value = 64'h0123_4567_89ab_cdef; it.has_exception = 1'b1;
        send_item(it);
        it = '0; it.func = FUNC_RENAME; it.arch_dest = 5'd2; it.arch_src_a = 5'd1;
        it.arch_src_b = 5'd31;
        send_item(it);
        it = '0; it.func = FUNC_WRITEBACK; it.phys_reg = 6'd33;
        it.write_value = 64'haaaa_5555_aaaa_5555;
        send_item(it);
        it = '0; it.func = FUNC_RENAME; it.arch_dest = 5'd3; it.arch_src_a = 5'd31;
        send_item(it);
        it = '0; it.func = FUNC_RETIRE; it.phys_reg = 6'd63;
        send_item(it);
        it = '0; it.func = FUNC_RETIRE; it.phys_reg = 6'd0;
        send_item(it);
        it = '0; it.func = FUNC_ROLLBACK; it.arch_dest = 5'd31; it.phys_reg = 6'd31;
        send_item(it);
        it = '0; it.func = FUNC_RENAME; it.arch_dest = 5'd31; it.arch_src_a = 5'd31;
        it.arch_src_b = 5'd31; it.b_is_immediate = 1'b1; it.immediate = -32'sd1;
        send_item(it);
        it = '0; it.func = FUNC_WRITEBACK; it.has_exception = 1'b1;
        send_item(it);
        it = '0; it.func = FUNC_ROLLBACK; it.phys_reg = 6'd0;
        send_item(it);
        it = '0; it.func = FUNC_RETIRE; it.phys_reg = 6'd32;
        send_item(it);
        it = '0; it.func = FUNC_RENAME; it.arch_dest = 5'd4; it.arch_src_a = 5'd2;
        it.arch_src_b = 5'd3;
        send_item(it);

        // The first phase drains the free list into stalls and the second refills
        // it; the rest mix the kinds in random proportions.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                rename_pct = 85;
                retire_pct = 5;
            end else if (ph == 1) begin
                rename_pct = 5;
                retire_pct = 80;
            end else begin
                rename_pct = $urandom_range(20, 60);
                retire_pct = $urandom_range(10, 35);
            end
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(rename_pct, retire_pct));
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        finished <= 1'b1;
        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
